/* src/segregated_pow2_block_allocator_defines.svh */
// Assertion macros shared by the allocator modules.
`ifndef SEGREGATED_POW2_BLOCK_ALLOCATOR_DEFINES_SVH
`define SEGREGATED_POW2_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define SPBA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("spba assertion failed");
`define SPBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spba assertion failed");
`else
`define SPBA_ASSERT(label, clk, rst, prop)
`define SPBA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* src/spba_pkg.sv */
// Shared constants, types and the size-to-class function of the allocator.
package spba_pkg;

   localparam int HEAP_LOG2_DEF   = 16;
   localparam int CHUNK_BYTES_DEF = 4096;
   localparam int NUM_CLASSES_DEF = 24;

   localparam int LINK_BYTES = 4;
   localparam int MIN_CLASS  = 3;
   localparam int SIZE_W     = 16;
   localparam int ADDR_W     = 16;
   localparam int CLASS_W    = 5;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic capture;
      logic pop_commit;
      logic free_commit;
      logic fill_start;
      logic fill_step;
      logic tag_commit;
      logic finish_null;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic alloc_reject;
      logic head_empty;
      logic overflow;
      logic free_bad;
      logic fill_multi;
      logic fill_last;
      logic rsp_free;
   } status_type;

   // smallest class c with size + 4 <= 2^c
   function automatic logic [CLASS_W-1:0] size_class(input logic [SIZE_W-1:0] size);
      logic [SIZE_W:0]    need;
      logic [CLASS_W-1:0] c;
      need = {1'b0, size} + (SIZE_W+1)'(LINK_BYTES - 1);
      c    = CLASS_W'(MIN_CLASS);
      for (int i = 0; i <= SIZE_W; i++) begin
         if (need[i]) begin
            c = CLASS_W'(i + 1);
         end
      end
      return c;
   endfunction

endpackage

/* src/spba_ctrl.sv */
// Controller state machine that sequences allocate, free and refill.
`include "segregated_pow2_block_allocator_defines.svh"

module spba_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  spba_pkg::status_type status,
   output spba_pkg::cmd_type   cmd
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DECIDE = 7'b0000010,
      S_POP    = 7'b0000100,
      S_FREE   = 7'b0001000,
      S_FILL   = 7'b0010000,
      S_TAG    = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (status.is_free) begin
               if (status.free_bad) begin
                  cmd.finish_null = 1'b1;
                  state_in        = S_DONE;
               end else begin
                  state_in = S_FREE;
               end
            end else begin
               priority if (status.alloc_reject) begin
                  cmd.finish_null = 1'b1;
                  state_in        = S_DONE;
               end else if (!status.head_empty) begin
                  state_in = S_POP;
               end else if (status.overflow) begin
                  cmd.finish_null = 1'b1;
                  state_in        = S_DONE;
               end else begin
                  cmd.fill_start = 1'b1;
                  state_in       = status.fill_multi ? S_FILL : S_TAG;
               end
            end
         end
         S_POP: begin
            cmd.pop_commit = 1'b1;
            state_in       = S_DONE;
         end
         S_FREE: begin
            cmd.free_commit = 1'b1;
            state_in        = S_DONE;
         end
         S_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = S_TAG;
            end
         end
         S_TAG: begin
            cmd.tag_commit = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SPBA_ASSERT_NEXT(a_accept_decide, clock, reset, accept, state_ff == S_DECIDE)
   `SPBA_ASSERT_NEXT(a_done_idle, clock, reset, (state_ff == S_DONE) && status.rsp_free, state_ff == S_IDLE)
   `SPBA_ASSERT_NEXT(a_fill_hold, clock, reset, (state_ff == S_FILL) && !status.fill_last, state_ff == S_FILL)

endmodule

/* src/spba_datapath.sv */
// Datapath: class heads, link word memory, heap break, refill walker and result registers.
`include "segregated_pow2_block_allocator_defines.svh"

module spba_datapath #(
   parameter int HEAP_LOG2   = spba_pkg::HEAP_LOG2_DEF,
   parameter int CHUNK_BYTES = spba_pkg::CHUNK_BYTES_DEF,
   parameter int NUM_CLASSES = spba_pkg::NUM_CLASSES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  spba_pkg::cmd_type             cmd,
   output spba_pkg::status_type          status,
   input  logic                          req_opcode,
   input  logic [spba_pkg::SIZE_W-1:0]   req_size,
   input  logic [spba_pkg::ADDR_W-1:0]   req_addr,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [spba_pkg::ADDR_W-1:0]   rsp_addr,
   output logic                          rsp_failed
);

   localparam int AW         = HEAP_LOG2;
   localparam int LIW        = AW - 3;
   localparam int LINK_DEPTH = 1 << LIW;
   localparam int CLW        = $clog2(NUM_CLASSES);
   localparam int CW         = (AW + 1 > spba_pkg::ADDR_W + 1) ? AW + 1 : spba_pkg::ADDR_W + 1;
   localparam int SW         = CW + 1;
   localparam int CHW        = $clog2(CHUNK_BYTES + 1);
   localparam int FCW        = $clog2((CHUNK_BYTES / 8) + 1);
   localparam int HEAP_BASE  = ((NUM_CLASSES * spba_pkg::LINK_BYTES + 7) / 8) * 8;
   localparam logic [SW-1:0] HEAP_SIZE = SW'(1) << AW;

   logic                           op_ff;
   logic                           size_zero_ff;
   logic [spba_pkg::CLASS_W-1:0]   class_ff;
   logic [spba_pkg::ADDR_W-1:0]    bp_ff;
   logic [AW:0]                    break_ff, break_in;
   logic [AW-1:0]                  walk_ff, walk_in;
   logic [FCW-1:0]                 remain_ff, remain_in;
   logic                           multi_ff;
   logic [AW-1:0]                  head_ff [NUM_CLASSES];
   logic [AW-1:0]                  link_mem [LINK_DEPTH];
   logic [AW-1:0]                  rd_data_ff;
   logic [spba_pkg::ADDR_W-1:0]    res_addr_ff;
   logic                           res_failed_ff;
   logic                           rsp_valid_ff;
   logic [spba_pkg::ADDR_W-1:0]    rsp_addr_ff;
   logic                           rsp_failed_ff;

   logic                           class_ok;
   logic [CLW-1:0]                 class_idx;
   logic [AW-1:0]                  head_sel;
   logic [AW:0]                    bsize;
   logic [CHW-1:0]                 chunk_c;
   logic [FCW-1:0]                 count;
   logic [SW-1:0]                  total;
   logic [CW-1:0]                  bp_ext;
   logic                           tag_ok;
   logic [CLW-1:0]                 tag_idx;
   logic [AW-1:0]                  tag_head;
   logic [AW:0]                    brk_plus;
   logic [AW:0]                    walk_next;
   logic [LIW-1:0]                 rd_idx;
   logic                           wr_en;
   logic [LIW-1:0]                 wr_idx;
   logic [AW-1:0]                  wr_data;
   logic [CW-1:0]                  head_wide;
   logic [CW-1:0]                  break_wide;

   assign class_ok  = ({1'b0, class_ff} <= 6'(HEAP_LOG2)) && ({1'b0, class_ff} < 6'(NUM_CLASSES));
   assign class_idx = class_ff[CLW-1:0];
   assign head_sel  = class_ok ? head_ff[class_idx] : '0;
   assign bsize     = {{AW{1'b0}}, 1'b1} << class_ff;
   assign chunk_c   = CHW'(CHUNK_BYTES) >> class_ff;
   assign count     = (chunk_c != '0) ? chunk_c[FCW-1:0] : FCW'(1);
   assign total     = SW'(count) << class_ff;
   assign bp_ext    = CW'(bp_ff);
   assign brk_plus  = break_ff + bsize;
   assign walk_next = (AW+1)'(walk_ff) + bsize;

   assign tag_ok   = (rd_data_ff >= AW'(spba_pkg::MIN_CLASS)) && (rd_data_ff <= AW'(HEAP_LOG2))
                     && (rd_data_ff < AW'(NUM_CLASSES));
   assign tag_idx  = rd_data_ff[CLW-1:0];
   assign tag_head = tag_ok ? head_ff[tag_idx] : '0;

   assign head_wide  = CW'(head_sel);
   assign break_wide = CW'(break_ff[AW-1:0]);

   assign status.is_free      = (op_ff == spba_pkg::OP_FREE);
   assign status.alloc_reject = size_zero_ff || !class_ok;
   assign status.head_empty   = (head_sel == '0);
   assign status.overflow     = (SW'(break_ff) + total) > HEAP_SIZE;
   assign status.free_bad     = (bp_ff[2:0] != 3'd0) || (bp_ext < CW'(HEAP_BASE))
                                || (bp_ext >= CW'(break_ff));
   assign status.fill_multi   = (chunk_c > CHW'(1));
   assign status.fill_last    = (remain_ff == FCW'(1));
   assign status.rsp_free     = !rsp_valid_ff || rsp_ready;

   assign rd_idx = (op_ff == spba_pkg::OP_FREE) ? bp_ext[AW-1:3] : head_sel[AW-1:3];

   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = '0;
      wr_data = '0;
      priority if (cmd.pop_commit) begin
         wr_en   = 1'b1;
         wr_idx  = head_sel[AW-1:3];
         wr_data = AW'(class_ff);
      end else if (cmd.free_commit) begin
         wr_en   = tag_ok;
         wr_idx  = bp_ext[AW-1:3];
         wr_data = tag_head;
      end else if (cmd.fill_step) begin
         wr_en   = 1'b1;
         wr_idx  = walk_ff[AW-1:3];
         wr_data = status.fill_last ? '0 : walk_next[AW-1:0];
      end else if (cmd.tag_commit) begin
         wr_en   = 1'b1;
         wr_idx  = break_ff[AW-1:3];
         wr_data = AW'(class_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= link_mem[rd_idx];
   end

   always_comb begin
      break_in  = break_ff;
      walk_in   = walk_ff;
      remain_in = remain_ff;
      if (cmd.fill_start) begin
         walk_in   = brk_plus[AW-1:0];
         remain_in = count - FCW'(1);
      end
      if (cmd.fill_step) begin
         walk_in   = walk_next[AW-1:0];
         remain_in = remain_ff - FCW'(1);
      end
      if (cmd.tag_commit) begin
         break_in = break_ff + total[AW:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff        <= req_opcode;
         size_zero_ff <= (req_size == '0);
         class_ff     <= spba_pkg::size_class(req_size);
         bp_ff        <= req_addr;
      end
      if (cmd.fill_start) begin
         multi_ff <= (chunk_c > CHW'(1));
      end
      walk_ff   <= walk_in;
      remain_ff <= remain_in;
      priority if (cmd.finish_null) begin
         res_addr_ff   <= '0;
         res_failed_ff <= (op_ff == spba_pkg::OP_ALLOC);
      end else if (cmd.pop_commit) begin
         res_addr_ff   <= head_wide[spba_pkg::ADDR_W-1:0];
         res_failed_ff <= 1'b0;
      end else if (cmd.free_commit) begin
         res_addr_ff   <= '0;
         res_failed_ff <= 1'b0;
      end else if (cmd.tag_commit) begin
         res_addr_ff   <= break_wide[spba_pkg::ADDR_W-1:0];
         res_failed_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_addr_ff   <= res_addr_ff;
         rsp_failed_ff <= res_failed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CLASSES; i++) begin
            head_ff[i] <= '0;
         end
         break_ff     <= (AW+1)'(HEAP_BASE);
         rsp_valid_ff <= 1'b0;
      end else begin
         break_ff <= break_in;
         priority if (cmd.pop_commit) begin
            head_ff[class_idx] <= rd_data_ff;
         end else if (cmd.free_commit && tag_ok) begin
            head_ff[tag_idx] <= bp_ext[AW-1:0];
         end else if (cmd.tag_commit) begin
            head_ff[class_idx] <= multi_ff ? brk_plus[AW-1:0] : '0;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_addr   = rsp_addr_ff;
   assign rsp_failed = rsp_failed_ff;

   `SPBA_ASSERT(a_break_aligned, clock, reset, break_ff[2:0] == 3'd0)
   `SPBA_ASSERT(a_break_bound, clock, reset, SW'(break_ff) <= HEAP_SIZE)
   `SPBA_ASSERT(a_pop_nonempty, clock, reset, !cmd.pop_commit || (head_sel != '0))

endmodule

/* src/segregated_pow2_block_allocator.sv */
// Top level of the power-of-two segregated free-list block allocator.
// Sequence: a request transfer is decided, then a pop or a free with a good address commits, and the
// response is registered; a failed allocate or a free with a bad address goes straight to the response.
// An empty class is refilled from the heap break, one link write per cycle, and its first block is tagged.
// A new request is taken only once the previous response has been loaded into the response register;
// a response held by rsp_tready stalls the controller. Reset: synchronous, lists empty, link RAM kept.
module segregated_pow2_block_allocator #(
   parameter int HEAP_LOG2   = spba_pkg::HEAP_LOG2_DEF,
   parameter int CHUNK_BYTES = spba_pkg::CHUNK_BYTES_DEF,
   parameter int NUM_CLASSES = spba_pkg::NUM_CLASSES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // request_size [15:0], block_addr [31:16]
   input  logic [0:0]  req_tuser,   // opcode [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // result_addr [15:0]
   output logic [0:0]  rsp_tuser    // failed [0]
);

   spba_pkg::cmd_type    cmd;
   spba_pkg::status_type status;

   spba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   spba_datapath #(
      .HEAP_LOG2   (HEAP_LOG2),
      .CHUNK_BYTES (CHUNK_BYTES),
      .NUM_CLASSES (NUM_CLASSES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_opcode (req_tuser[0]),
      .req_size   (req_tdata[15:0]),
      .req_addr   (req_tdata[31:16]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_addr   (rsp_tdata),
      .rsp_failed (rsp_tuser[0])
   );

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the segregated power-of-two block allocator.
module testbench;
   import spba_pkg::*;

   localparam int HEAP_LOG2   = HEAP_LOG2_DEF;
   localparam int CHUNK_BYTES = CHUNK_BYTES_DEF;
   localparam int NUM_CLASSES = NUM_CLASSES_DEF;
   localparam int HEAP_BYTES  = 1 << HEAP_LOG2;
   localparam int LINK_DEPTH  = HEAP_BYTES / 8;
   localparam int HEAP_BASE   = ((NUM_CLASSES * LINK_BYTES + 7) / 8) * 8;
   localparam int PHASE_ITEMS = 384;

   typedef struct packed {
      logic        opcode;
      logic [15:0] size;
      logic [15:0] addr;
   } alloc_req_t;

   typedef struct packed {
      logic [15:0] addr;
      logic        failed;
   } grant_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // request_size [15:0], block_addr [31:16]
   logic [0:0]  req_tuser = '0;   // opcode [0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // result_addr [15:0]
   logic [0:0]  rsp_tuser;        // failed [0]

   segregated_pow2_block_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic [15:0] class_head [NUM_CLASSES];
   logic [15:0] link_mem [LINK_DEPTH];
   bit          granule_written [LINK_DEPTH];
   int unsigned heap_top = HEAP_BASE;

   alloc_req_t  pending_requests [$];
   grant_t      expected_grants [$];
   logic [15:0] live_blocks [$];
   logic [15:0] freed_blocks [$];
   alloc_req_t  cur_req;
   grant_t      grant;
   grant_t      want;
   logic [15:0] last_grant = '0;
   bit          req_busy = 1'b0;
   bit          req_taken = 1'b0;
   int          outstanding = 0;
   int          mismatch_count = 0;
   int          req_idle_pct = 15;
   int          rsp_stall_pct = 49;

   initial begin
      foreach (class_head[i]) class_head[i] = '0;
      foreach (link_mem[i]) link_mem[i] = '0;
   end

   function automatic int unsigned link_slot(int unsigned a);
      return (a >> 3) & (LINK_DEPTH - 1);
   endfunction

   function automatic void write_link(int unsigned a, int unsigned v);
      link_mem[link_slot(a)] = 16'(v);
      granule_written[link_slot(a)] = 1'b1;
   endfunction

   task automatic apply_request(input alloc_req_t r, output grant_t res);
      int unsigned c;
      int unsigned bsize;
      int unsigned count;
      int unsigned bp;
      int unsigned need;
      res = '0;
      if (r.opcode == OP_ALLOC) begin
         if (r.size == 0) begin
            res.failed = 1'b1;
            return;
         end
         need = r.size + LINK_BYTES;
         c = MIN_CLASS;
         while (need > (32'd1 << c) && c < 31) c++;
         if (c > HEAP_LOG2 || c >= NUM_CLASSES) begin
            res.failed = 1'b1;
            return;
         end
         if (class_head[c] == 0) begin
            bsize = 32'd1 << c;
            count = (bsize <= CHUNK_BYTES) ? CHUNK_BYTES / bsize : 1;
            if (heap_top + count * bsize > HEAP_BYTES) begin
               res.failed = 1'b1;
               return;
            end
            bp = heap_top;
            heap_top += count * bsize;
            class_head[c] = 16'(bp);
            for (int unsigned i = 0; i + 1 < count; i++) begin
               write_link(bp + i * bsize, bp + (i + 1) * bsize);
            end
            write_link(bp + (count - 1) * bsize, 0);
         end
         bp = class_head[c];
         class_head[c] = link_mem[link_slot(bp)];
         write_link(bp, c);
         res.addr = 16'(bp);
      end else begin
         bp = r.addr;
         if (bp[2:0] == 3'd0 && bp >= HEAP_BASE && bp < heap_top) begin
            c = link_mem[link_slot(bp)];
            if (c >= MIN_CLASS && c <= HEAP_LOG2 && c < NUM_CLASSES) begin
               write_link(bp, class_head[c]);
               class_head[c] = 16'(bp);
            end
         end
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         if (!req_tvalid || req_taken) begin
            req_taken = 1'b0;
            if (pending_requests.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               cur_req = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= cur_req.opcode;
               req_tdata <= {cur_req.addr, cur_req.size};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_grants.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected transfer: addr %h failed %b", rsp_tdata, rsp_tuser[0]);
               mismatch_count++;
            end else begin
               want = expected_grants.pop_front();
               outstanding--;
               if (rsp_tdata !== want.addr || rsp_tuser[0] !== want.failed) begin
                  if (mismatch_count < 10)
                     $display("mismatch: expected addr %h failed %b, got addr %h failed %b",
                              want.addr, want.failed, rsp_tdata, rsp_tuser[0]);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            apply_request(cur_req, grant);
            expected_grants.push_back(grant);
            outstanding++;
            if (cur_req.opcode == OP_ALLOC && !grant.failed) begin
               live_blocks.push_back(grant.addr);
               last_grant = grant.addr;
            end
            if (cur_req.opcode == OP_FREE) begin
               for (int k = 0; k < live_blocks.size(); k++) begin
                  if (live_blocks[k] == cur_req.addr) begin
                     live_blocks.delete(k);
                     freed_blocks.push_back(cur_req.addr);
                     if (freed_blocks.size() > 64) void'(freed_blocks.pop_front());
                     break;
                  end
               end
            end
            req_taken = 1'b1;
            req_busy = 1'b0;
         end
      end
   end

   task automatic send_request(input logic op, input logic [15:0] size,
                               input logic [15:0] addr);
      alloc_req_t r;
      r.opcode = op;
      r.size = size;
      r.addr = addr;
      wait (!req_busy);
      req_busy = 1'b1;
      pending_requests.push_back(r);
   endtask

   function automatic alloc_req_t random_request();
      alloc_req_t r;
      int unsigned roll;
      r.size = 16'($urandom);
      r.addr = 16'($urandom);
      roll = $urandom_range(99);
      if (roll < 55) begin
         r.opcode = OP_ALLOC;
         roll = $urandom_range(99);
         if (roll < 60) r.size = 16'($urandom_range(60, 1));
         else if (roll < 82) r.size = 16'($urandom_range(1000, 61));
         else if (roll < 94) r.size = 16'($urandom_range(4092, 1001));
         else if (roll < 97) r.size = 16'($urandom_range(16380, 4093));
         else if (roll == 99) r.size = '0;
      end else begin
         r.opcode = OP_FREE;
         roll = $urandom_range(99);
         if (roll < 75 && live_blocks.size() != 0) begin
            r.addr = live_blocks[$urandom_range(live_blocks.size() - 1)];
         end else if (roll < 85 && freed_blocks.size() != 0) begin
            r.addr = freed_blocks[$urandom_range(freed_blocks.size() - 1)];
         end else if (r.addr[2:0] == 3'd0 && r.addr >= HEAP_BASE && r.addr < heap_top
                      && !granule_written[link_slot(r.addr)]) begin
            r.addr[0] = 1'b1;
         end
      end
      return r;
   endfunction

   initial begin
      alloc_req_t  r;
      logic [15:0] blk;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      send_request(OP_ALLOC, 16'd0, 16'hFFFF);
      send_request(OP_ALLOC, 16'hFFFF, 16'd0);
      send_request(OP_ALLOC, 16'd65532, 16'h8000);
      send_request(OP_ALLOC, 16'd8188, 16'd0);
      wait (!req_busy);
      blk = last_grant;
      send_request(OP_FREE, 16'hFFFF, blk);
      send_request(OP_FREE, 16'd0, blk);
      send_request(OP_ALLOC, 16'd8188, 16'd0);
      send_request(OP_ALLOC, 16'd1, 16'd0);
      wait (!req_busy);
      blk = last_grant;
      send_request(OP_ALLOC, 16'd4, 16'd0);
      send_request(OP_FREE, 16'd0, blk + 16'd16);
      send_request(OP_ALLOC, 16'd5, 16'd0);
      wait (!req_busy);
      blk = last_grant;
      send_request(OP_FREE, 16'd0, blk + 16'd1);
      send_request(OP_FREE, 16'd0, 16'd0);
      send_request(OP_FREE, 16'd0, 16'd88);
      wait (!req_busy);
      send_request(OP_FREE, 16'd0, 16'(heap_top));
      send_request(OP_FREE, 16'd0, 16'hFFF8);
      send_request(OP_FREE, 16'd0, blk);
      send_request(OP_ALLOC, 16'd12, 16'd0);
      send_request(OP_ALLOC, 16'd4092, 16'd0);
      send_request(OP_ALLOC, 16'd16380, 16'd0);
      send_request(OP_ALLOC, 16'd32764, 16'd0);

      for (int phase = 0; phase < 3; phase++) begin
         wait (!req_busy && outstanding == 0);
         req_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 49 : 0;
         rsp_stall_pct = (phase == 0) ? 49 : (phase == 1) ? 15 : 0;
         for (int n = 0; n < PHASE_ITEMS - 2 * (phase / 2); n++) begin
            wait (!req_busy);
            r = random_request();
            send_request(r.opcode, r.size, r.addr);
         end
      end

      wait (!req_busy && outstanding == 0);
      repeat (600) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
